// File: rtl/core/itr_pkg.sv
`default_nettype none
package itr_pkg;

  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned MAX_RUN    = 4;

  localparam logic [7:0] ASCII_M = 8'h4D;
  localparam logic [7:0] ASCII_D = 8'h44;
  localparam logic [7:0] ASCII_C = 8'h43;
  localparam logic [7:0] ASCII_L = 8'h4C;
  localparam logic [7:0] ASCII_X = 8'h58;
  localparam logic [7:0] ASCII_V = 8'h56;
  localparam logic [7:0] ASCII_I = 8'h49;

  // digit positions, most significant first
  localparam logic [1:0] POS_THOU = 2'd0;
  localparam logic [1:0] POS_HUND = 2'd1;
  localparam logic [1:0] POS_TENS = 2'd2;
  localparam logic [1:0] POS_UNIT = 2'd3;

  typedef enum logic [1:0] {
    SEL_ONE,
    SEL_FIVE,
    SEL_TEN
  } sel_t;

  // letter run for one decimal digit
  typedef struct packed {
    logic [2:0]       len;
    sel_t [MAX_RUN-1:0] sel;
  } digit_plan_t;

  typedef struct packed {
    digit_plan_t [NUM_DIGITS-1:0] dig;
  } item_plan_t;

  function automatic digit_plan_t digit_plan(input logic [3:0] d, input logic thousands);
    digit_plan_t p;
    p.len = 3'd0;
    for (int unsigned j = 0; j < MAX_RUN; j++) begin
      p.sel[j] = SEL_ONE;
    end
    if (thousands) begin
      // no letter for five thousand: additive only
      p.len = d[2:0];
    end else begin
      case (d)
        4'd0: p.len = 3'd0;
        4'd1: p.len = 3'd1;
        4'd2: p.len = 3'd2;
        4'd3: p.len = 3'd3;
        4'd4: begin
          p.len    = 3'd2;
          p.sel[1] = SEL_FIVE;
        end
        4'd5: begin
          p.len    = 3'd1;
          p.sel[0] = SEL_FIVE;
        end
        4'd6: begin
          p.len    = 3'd2;
          p.sel[0] = SEL_FIVE;
        end
        4'd7: begin
          p.len    = 3'd3;
          p.sel[0] = SEL_FIVE;
        end
        4'd8: begin
          p.len    = 3'd4;
          p.sel[0] = SEL_FIVE;
        end
        4'd9: begin
          p.len    = 3'd2;
          p.sel[1] = SEL_TEN;
        end
        default: p.len = 3'd0;
      endcase
    end
    return p;
  endfunction

  function automatic logic [7:0] letter(input logic [1:0] pos, input sel_t sel);
    logic [7:0] c;
    c = ASCII_I;
    case (pos)
      POS_THOU: c = ASCII_M;
      POS_HUND: begin
        case (sel)
          SEL_ONE:  c = ASCII_C;
          SEL_FIVE: c = ASCII_D;
          SEL_TEN:  c = ASCII_M;
          default:  c = ASCII_C;
        endcase
      end
      POS_TENS: begin
        case (sel)
          SEL_ONE:  c = ASCII_X;
          SEL_FIVE: c = ASCII_L;
          SEL_TEN:  c = ASCII_C;
          default:  c = ASCII_X;
        endcase
      end
      POS_UNIT: begin
        case (sel)
          SEL_ONE:  c = ASCII_I;
          SEL_FIVE: c = ASCII_V;
          SEL_TEN:  c = ASCII_X;
          default:  c = ASCII_I;
        endcase
      end
      default: c = ASCII_I;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/itr_front.sv
`default_nettype none
module itr_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic [11:0]        value,
  output logic                    enq_valid,
  output itr_pkg::item_plan_t     enq_data,
  input  wire logic               q_full
);

  logic       s1_valid;
  logic [2:0] s1_thou;
  logic [9:0] s1_rem;
  logic       s2_valid;
  logic [2:0] s2_thou;
  logic [3:0] s2_hund;
  logic [6:0] s2_rem;

  logic       s1_free, s2_free, s1_move, accept;
  logic [2:0] thou;
  logic [9:0] rem_thou;
  logic [3:0] hund;
  logic [6:0] rem_hund;
  logic [3:0] tens;
  logic [3:0] unit;

  assign s2_free    = !s2_valid || !q_full;
  assign s1_move    = s1_valid && s2_free;
  assign s1_free    = !s1_valid || s2_free;
  assign item_stall = !s1_free;
  assign accept     = item_valid && s1_free;

  // thousands split
  always_comb begin
    if (value >= 12'd4000) begin
      thou = 3'd4;  rem_thou = 10'(value - 12'd4000);
    end else if (value >= 12'd3000) begin
      thou = 3'd3;  rem_thou = 10'(value - 12'd3000);
    end else if (value >= 12'd2000) begin
      thou = 3'd2;  rem_thou = 10'(value - 12'd2000);
    end else if (value >= 12'd1000) begin
      thou = 3'd1;  rem_thou = 10'(value - 12'd1000);
    end else begin
      thou = 3'd0;  rem_thou = value[9:0];
    end
  end

  // hundreds split, remainder below 1000
  always_comb begin
    if      (s1_rem >= 10'd900) begin hund = 4'd9; rem_hund = 7'(s1_rem - 10'd900); end
    else if (s1_rem >= 10'd800) begin hund = 4'd8; rem_hund = 7'(s1_rem - 10'd800); end
    else if (s1_rem >= 10'd700) begin hund = 4'd7; rem_hund = 7'(s1_rem - 10'd700); end
    else if (s1_rem >= 10'd600) begin hund = 4'd6; rem_hund = 7'(s1_rem - 10'd600); end
    else if (s1_rem >= 10'd500) begin hund = 4'd5; rem_hund = 7'(s1_rem - 10'd500); end
    else if (s1_rem >= 10'd400) begin hund = 4'd4; rem_hund = 7'(s1_rem - 10'd400); end
    else if (s1_rem >= 10'd300) begin hund = 4'd3; rem_hund = 7'(s1_rem - 10'd300); end
    else if (s1_rem >= 10'd200) begin hund = 4'd2; rem_hund = 7'(s1_rem - 10'd200); end
    else if (s1_rem >= 10'd100) begin hund = 4'd1; rem_hund = 7'(s1_rem - 10'd100); end
    else begin hund = 4'd0; rem_hund = s1_rem[6:0]; end
  end

  // tens and units, remainder below 100
  always_comb begin
    if      (s2_rem >= 7'd90) begin tens = 4'd9; unit = 4'(s2_rem - 7'd90); end
    else if (s2_rem >= 7'd80) begin tens = 4'd8; unit = 4'(s2_rem - 7'd80); end
    else if (s2_rem >= 7'd70) begin tens = 4'd7; unit = 4'(s2_rem - 7'd70); end
    else if (s2_rem >= 7'd60) begin tens = 4'd6; unit = 4'(s2_rem - 7'd60); end
    else if (s2_rem >= 7'd50) begin tens = 4'd5; unit = 4'(s2_rem - 7'd50); end
    else if (s2_rem >= 7'd40) begin tens = 4'd4; unit = 4'(s2_rem - 7'd40); end
    else if (s2_rem >= 7'd30) begin tens = 4'd3; unit = 4'(s2_rem - 7'd30); end
    else if (s2_rem >= 7'd20) begin tens = 4'd2; unit = 4'(s2_rem - 7'd20); end
    else if (s2_rem >= 7'd10) begin tens = 4'd1; unit = 4'(s2_rem - 7'd10); end
    else begin tens = 4'd0; unit = s2_rem[3:0]; end
  end

  assign enq_valid = s2_valid;
  always_comb begin
    enq_data.dig[itr_pkg::POS_THOU] = itr_pkg::digit_plan({1'b0, s2_thou}, 1'b1);
    enq_data.dig[itr_pkg::POS_HUND] = itr_pkg::digit_plan(s2_hund, 1'b0);
    enq_data.dig[itr_pkg::POS_TENS] = itr_pkg::digit_plan(tens, 1'b0);
    enq_data.dig[itr_pkg::POS_UNIT] = itr_pkg::digit_plan(unit, 1'b0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= item_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_thou <= thou;
      s1_rem  <= rem_thou;
    end
    if (s1_move) begin
      s2_thou <= s1_thou;
      s2_hund <= hund;
      s2_rem  <= rem_hund;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/itr_queue.sv
`default_nettype none
module itr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               enq_valid,
  input  wire itr_pkg::item_plan_t enq_data,
  output logic                    full,
  output logic                    empty,
  input  wire logic               pop,
  output itr_pkg::item_plan_t     head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  itr_pkg::item_plan_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign push  = enq_valid && !full;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= enq_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/itr_back.sv
`default_nettype none
module itr_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_empty,
  input  wire itr_pkg::item_plan_t head,
  output logic                    pop,
  output logic                    char_valid,
  input  wire logic               char_stall,
  output logic [7:0]              symbol,
  output logic                    has_symbol,
  output logic                    last
);

  logic       started;
  logic [3:0] remain;
  logic [1:0] k;

  logic [3:0] head_mask;
  logic [3:0] cur_mask;
  logic [3:0] rest_mask;
  logic [1:0] pos;
  logic [2:0] cur_len;
  logic       digit_done;
  logic       fire;
  logic       last_next;
  logic [7:0] symbol_next;
  itr_pkg::sel_t cur_sel;

  always_comb begin
    for (int i = 0; i < itr_pkg::NUM_DIGITS; i++) begin
      head_mask[i] = (head.dig[i].len != 3'd0);
    end
  end

  assign cur_mask = started ? remain : head_mask;

  // lowest set bit is the most significant digit still to go
  always_comb begin
    pos = 2'd0;
    for (int i = itr_pkg::NUM_DIGITS - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        pos = 2'(i);
      end
    end
  end

  assign cur_len     = head.dig[pos].len;
  assign cur_sel     = head.dig[pos].sel[k];
  assign digit_done  = ({1'b0, k} == cur_len - 3'd1);
  assign rest_mask   = cur_mask & ~(4'b0001 << pos);
  assign last_next   = (cur_mask == 4'd0) || (digit_done && (rest_mask == 4'd0));
  assign symbol_next = (cur_mask == 4'd0) ? 8'd0 : itr_pkg::letter(pos, cur_sel);

  assign fire = !q_empty && (!char_valid || !char_stall);
  assign pop  = fire && last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      started    <= 1'b0;
      remain     <= 4'd0;
      k          <= 2'd0;
    end else begin
      if (fire) begin
        char_valid <= 1'b1;
        if (last_next) begin
          started <= 1'b0;
          k       <= 2'd0;
        end else begin
          started <= 1'b1;
          if (digit_done) begin
            remain <= rest_mask;
            k      <= 2'd0;
          end else begin
            remain <= cur_mask;
            k      <= k + 2'd1;
          end
        end
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      symbol     <= symbol_next;
      has_symbol <= (cur_mask != 4'd0);
      last       <= last_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/integer_to_roman_numeral.sv
// Integer to Roman numeral converter. Each input word is a 12-bit value
// (0..3999 nominally; 4000..4095 gives a leading MMMM) and produces its
// numeral as one output word per ASCII letter, most significant first, with
// last set on the final letter. A zero input gives a single word with
// has_symbol low and last high. While char_stall is low and the queue is not
// empty, the output runs at one letter per cycle without gaps between items;
// an item gives one output word per letter of its numeral, 1 to 15 words.
// An input value reaches the first letter through two digit-split stages,
// the queue and the output register. The digit queue (QUEUE_DEPTH entries)
// lets new values be split while a long numeral is still being sent.
`default_nettype none
module integer_to_roman_numeral #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [11:0] value,
  output logic             char_valid,
  input  wire logic        char_stall,
  output logic [7:0]       symbol,
  output logic             has_symbol,
  output logic             last
);

  logic                enq_valid;
  itr_pkg::item_plan_t enq_data;
  itr_pkg::item_plan_t head;
  logic                q_full;
  logic                q_empty;
  logic                pop;

  itr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .value      (value),
    .enq_valid  (enq_valid),
    .enq_data   (enq_data),
    .q_full     (q_full)
  );

  itr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .enq_valid (enq_valid),
    .enq_data  (enq_data),
    .full      (q_full),
    .empty     (q_empty),
    .pop       (pop),
    .head      (head)
  );

  itr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .symbol     (symbol),
    .has_symbol (has_symbol),
    .last       (last)
  );

endmodule
`default_nettype wire

// File: rtl/core/itr_checker.sv
`default_nettype none
module itr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       char_valid,
  input wire logic       char_stall,
  input wire logic [7:0] symbol,
  input wire logic       has_symbol,
  input wire logic       last
);

  // empty result stands alone
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !has_symbol) |-> last)
    else $error("empty result without last");

  a_empty_no_letter: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !has_symbol) |-> (symbol == 8'd0))
    else $error("empty result carries a letter");

  a_letter_code: assert property (@(posedge clk) disable iff (rst)
    (char_valid && has_symbol) |->
      (symbol == itr_pkg::ASCII_M || symbol == itr_pkg::ASCII_D ||
       symbol == itr_pkg::ASCII_C || symbol == itr_pkg::ASCII_L ||
       symbol == itr_pkg::ASCII_X || symbol == itr_pkg::ASCII_V ||
       symbol == itr_pkg::ASCII_I))
    else $error("symbol is not a numeral letter");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_stall) |=> char_valid)
    else $error("word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_stall) |=>
      ($stable(symbol) && $stable(has_symbol) && $stable(last)))
    else $error("word changed while stalled");

endmodule

bind integer_to_roman_numeral itr_checker u_itr_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .symbol     (symbol),
  .has_symbol (has_symbol),
  .last       (last)
);
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
module testbench;

  typedef struct packed {
    logic [7:0] sym;
    logic       has;
    logic       fin;
  } letter_t;

  localparam int DIR_N      = 21;
  localparam int RAND_N     = 140;
  localparam int IDLE_PCT   = 37;
  localparam int HOLD_LEN   = 250;
  localparam int DRAIN_WAIT = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [11:0] value = '0;
  logic        char_valid;
  logic        char_stall = 1'b0;
  logic [7:0]  symbol;
  logic        has_symbol;
  logic        last;

  letter_t pending_letters[$];
  int      mismatch_count = 0;
  bit      no_idle = 1'b0;
  bit      hold_request = 1'b0;

  // directed rows: typed rows carry their numeral, the rest go through the predictor
  logic [11:0] dir_value [DIR_N] = '{
    12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd3, 12'd8, 12'd40, 12'd90, 12'd400, 12'd900,
    12'd1000, 12'd3000, 12'd3999, 12'd3888, 12'd4000, 12'd4095, 12'd444, 12'hAAA,
    12'h555, 12'd0
  };
  bit dir_typed [DIR_N] = '{
    1, 1, 1, 1, 1, 0, 0, 1, 1, 1, 1,
    1, 1, 1, 1, 1, 1, 0, 0,
    0, 1
  };
  string dir_text [DIR_N] = '{
    "", "I", "IV", "V", "IX", "", "", "XL", "XC", "CD", "CM",
    "M", "MMM", "MMMCMXCIX", "MMMDCCCLXXXVIII", "MMMM", "MMMMXCV", "", "",
    "", ""
  };

  integer_to_roman_numeral u_dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .value      (value),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .symbol     (symbol),
    .has_symbol (has_symbol),
    .last       (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // queue a numeral's letters, marking the final one; empty numeral gives the zero word
  function automatic void queue_letters(input logic [7:0] chars [$]);
    letter_t w;
    if (chars.size() == 0) begin
      w = '{sym: 8'h00, has: 1'b0, fin: 1'b1};
      pending_letters.push_back(w);
    end else begin
      for (int i = 0; i < chars.size(); i++) begin
        w = '{sym: chars[i], has: 1'b1, fin: (i == chars.size() - 1)};
        pending_letters.push_back(w);
      end
    end
  endfunction

  function automatic void spell_text(input string s);
    logic [7:0] chars [$];
    for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
    queue_letters(chars);
  endfunction

  function automatic void spell_roman(input logic [11:0] v);
    logic [7:0]  ones  [4];
    logic [7:0]  fives [4];
    logic [7:0]  tens  [4];
    logic [7:0]  chars [$];
    int unsigned rest;
    int unsigned scale;
    int unsigned dig;
    ones  = '{itr_pkg::ASCII_M, itr_pkg::ASCII_C, itr_pkg::ASCII_X, itr_pkg::ASCII_I};
    fives = '{8'h00, itr_pkg::ASCII_D, itr_pkg::ASCII_L, itr_pkg::ASCII_V};
    tens  = '{8'h00, itr_pkg::ASCII_M, itr_pkg::ASCII_C, itr_pkg::ASCII_X};
    rest  = v;
    scale = 1000;
    for (int p = 0; p < 4; p++) begin
      dig   = rest / scale;
      rest  = rest % scale;
      scale = scale / 10;
      if (p == 0) begin
        // thousands have no five letter, so 4000 and up is MMMM
        repeat (dig) chars.push_back(ones[p]);
      end else if (dig == 9) begin
        chars.push_back(ones[p]);
        chars.push_back(tens[p]);
      end else if (dig == 4) begin
        chars.push_back(ones[p]);
        chars.push_back(fives[p]);
      end else begin
        if (dig >= 5) begin
          chars.push_back(fives[p]);
          dig = dig - 5;
        end
        repeat (dig) chars.push_back(ones[p]);
      end
    end
    queue_letters(chars);
  endfunction

  task automatic send_word(input logic [11:0] v, input bit typed, input string text);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    value      <= v;
    do @(posedge clk); while (item_stall);
    if (typed) spell_text(text);
    else spell_roman(v);
  endtask

  // sender
  initial begin
    logic [11:0] v;
    int unsigned r;
    wait (!rst);
    @(posedge clk);
    for (int i = 0; i < DIR_N; i++) send_word(dir_value[i], dir_typed[i], dir_text[i]);
    for (int i = 0; i < RAND_N; i++) begin
      no_idle = (i >= 60 && i < 100);
      if (i == 110) hold_request = 1'b1;
      r = $urandom_range(99);
      if (r < 5) v = 12'd0;
      else if (r < 15) v = 12'($urandom_range(4095, 4000));
      else if (r < 25) v = 12'($urandom);
      else v = 12'($urandom_range(3999, 1));
      send_word(v, 1'b0, "");
    end
    no_idle = 1'b0;
    item_valid <= 1'b0;
    while (pending_letters.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver, with one long hold-off so the block backs up into its input
  initial begin
    int unsigned hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_request && !held) begin
        hold_left = HOLD_LEN;
        held      = 1'b1;
      end
      if (hold_left > 0) begin
        char_stall <= 1'b1;
        hold_left--;
      end else if (no_idle) begin
        char_stall <= 1'b0;
      end else begin
        char_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    letter_t got;
    letter_t want;
    if (!rst && char_valid && !char_stall) begin
      got = '{sym: symbol, has: has_symbol, fin: last};
      if (pending_letters.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: symbol=%h has_symbol=%b last=%b",
                   got.sym, got.has, got.fin);
      end else begin
        want = pending_letters.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: symbol exp %h got %h, has_symbol exp %b got %b,",
                      " last exp %b got %b"},
                     want.sym, got.sym, want.has, got.has, want.fin, got.fin);
        end
      end
    end
  end

endmodule
